/* src/shadow_memory_access_checker_core_assert.svh */
// assertion macros used by the shadow memory access checker controller
`ifndef SHADOW_MEMORY_ACCESS_CHECKER_CORE_ASSERT_SVH
`define SHADOW_MEMORY_ACCESS_CHECKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define SMAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shadow checker: assertion failed");
// next-cycle implication, checked outside reset
`define SMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shadow checker: assertion failed");
`else
`define SMAC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/smac_pkg.sv */
// shared constants, codes and control types of the shadow memory access checker
package smac_pkg;

    localparam int unsigned SHADOW_ENTRIES = 65536;
    localparam int unsigned SH_ADDR_W = (SHADOW_ENTRIES > 1) ? $clog2(SHADOW_ENTRIES) : 1;
    localparam int unsigned SH_CNT_W  = $clog2(SHADOW_ENTRIES + 1);

    localparam int unsigned ACT_W     = 2;
    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 64;
    // block index of an exclusive range end, up to 2^30
    localparam int unsigned IDX_W     = 31;

    localparam logic [ACT_W-1:0] ACT_POISON   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UNPOISON = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CHECK    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd1;

    localparam logic [3:0] PREFIX_FULL = 4'd8;

    typedef struct packed {
        logic load;
        logic offset;
        logic clip;
        logic bound;
        logic limit;
        logic walk;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic reject;
        logic walk_done;
        logic clear_done;
    } dp_stat_t;

endpackage

/* src/smac_datapath.sv */
// datapath: region registers, range clipping, block walk and the shadow memory
module smac_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_fill,
    input  logic [smac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smac_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic [smac_pkg::ACT_W-1:0]      action,
    input  logic [smac_pkg::ADDR_W-1:0]     address,
    input  logic [smac_pkg::LEN_W-1:0]      length,
    input  smac_pkg::dp_cmd_t               cmd,
    output smac_pkg::dp_stat_t              stat,
    output logic                            fault
);

    // region registers and entries in use
    logic [smac_pkg::ADDR_W-1:0]   region_base_reg;
    logic [smac_pkg::LEN_W-1:0]    region_size_reg;
    logic [smac_pkg::SH_CNT_W-1:0] n_reg;
    logic [smac_pkg::SH_CNT_W-1:0] n_next;
    logic [smac_pkg::LEN_W:0]      size_round;
    logic [29:0]                   size_blocks;

    // item and working registers
    logic [smac_pkg::ACT_W-1:0]    action_reg;
    logic [smac_pkg::ADDR_W-1:0]   addr_reg;
    logic [smac_pkg::LEN_W-1:0]    len_reg;
    logic [smac_pkg::ADDR_W:0]     off_reg;
    logic [smac_pkg::ADDR_W:0]     off_next;
    logic [smac_pkg::LEN_W:0]      e_raw_reg;
    logic [smac_pkg::LEN_W-1:0]    s_reg;
    logic [smac_pkg::IDX_W-1:0]    stop_raw_reg;
    logic [smac_pkg::IDX_W-1:0]    last_reg;
    logic [smac_pkg::SH_CNT_W-1:0] stop_reg;
    logic [2:0]                    tail_reg;
    logic [smac_pkg::IDX_W-1:0]    idx_reg;
    logic                          reject_reg;
    logic                          reject_next;
    logic                          first_flag_reg;
    logic                          pend_reg;
    logic                          pend_last_reg;
    logic                          fault_reg;

    // shadow store
    logic [3:0] shadow_mem [smac_pkg::SHADOW_ENTRIES];
    logic [3:0] rd_data_reg;

    // clip stage
    logic                          ge;
    logic [smac_pkg::ADDR_W+1:0]   t_sum;
    logic                          off_ge_size;
    logic                          t_nonpos;
    logic                          base_zero;
    logic                          is_check;
    logic                          is_mark;
    logic                          is_unpoison;

    // bound stage
    logic [smac_pkg::LEN_W:0]      e_clip;
    logic [smac_pkg::LEN_W:0]      e_sel;
    logic [smac_pkg::LEN_W+1:0]    e_round;

    // walk
    logic                          in_range;
    logic                          in_fill;
    logic                          at_last;
    logic                          issue;
    logic                          mark_we;
    logic                          clear_we;
    logic                          mem_we;
    logic [3:0]                    mark_val;
    logic [3:0]                    mem_wd;
    logic [2:0]                    hi_byte;
    logic                          hit;

    assign size_round  = {1'b0, cfg_data[smac_pkg::LEN_W-1:0]} + 33'd7;
    assign size_blocks = size_round[32:3];
    assign n_next = (size_blocks > 30'(smac_pkg::SHADOW_ENTRIES))
                  ? smac_pkg::SH_CNT_W'(smac_pkg::SHADOW_ENTRIES)
                  : size_blocks[smac_pkg::SH_CNT_W-1:0];

    assign base_zero   = (region_base_reg == '0);
    assign is_check    = (action_reg == smac_pkg::ACT_CHECK);
    assign is_unpoison = (action_reg == smac_pkg::ACT_UNPOISON);
    assign is_mark     = (action_reg == smac_pkg::ACT_POISON) || is_unpoison;

    // offset into region, bit 64 set when the address is below the base
    assign off_next = {1'b0, addr_reg} - {1'b0, region_base_reg};

    assign ge          = !off_reg[smac_pkg::ADDR_W];
    assign t_sum       = {off_reg[smac_pkg::ADDR_W], off_reg} + {34'd0, len_reg};
    assign off_ge_size = (off_reg[63:32] != '0) || (off_reg[31:0] >= region_size_reg);
    assign t_nonpos    = t_sum[smac_pkg::ADDR_W+1] || (t_sum == '0);

    always_comb
    begin
        if (base_zero || (len_reg == '0))
            reject_next = 1'b1;
        else if (is_check)
            reject_next = !ge || off_ge_size;
        else if (is_mark)
            reject_next = ge ? off_ge_size : t_nonpos;
        else
            reject_next = 1'b1;
    end

    // marking clips the end to the region, a check keeps its own last byte
    assign e_clip  = (e_raw_reg > {1'b0, region_size_reg}) ? {1'b0, region_size_reg}
                                                           : e_raw_reg;
    assign e_sel   = is_check ? e_raw_reg : e_clip;
    assign e_round = {1'b0, e_sel} + 34'd7;

    assign in_range = idx_reg < smac_pkg::IDX_W'(stop_reg);
    assign in_fill  = idx_reg < smac_pkg::IDX_W'(n_reg);
    assign at_last  = (idx_reg == last_reg);

    assign issue    = cmd.walk && is_check && in_range && !fault_reg;
    assign mark_we  = cmd.walk && !is_check && in_range;
    assign clear_we = cmd.clear && in_fill;
    assign mem_we   = mark_we || clear_we;

    always_comb
    begin
        if (is_unpoison)
            mark_val = (at_last && (tail_reg != 3'd0)) ? {1'b0, tail_reg}
                                                       : smac_pkg::PREFIX_FULL;
        else
            mark_val = first_flag_reg ? {1'b0, s_reg[2:0]} : 4'd0;
    end

    assign mem_wd = clear_we ? smac_pkg::PREFIX_FULL : mark_val;

    // highest byte touched in the block under test
    assign hi_byte = pend_last_reg ? (tail_reg - 3'd1) : 3'd7;
    assign hit     = pend_reg && (rd_data_reg < smac_pkg::PREFIX_FULL)
                  && ({1'b0, hi_byte} >= rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            shadow_mem[idx_reg[smac_pkg::SH_ADDR_W-1:0]] <= mem_wd;
        rd_data_reg <= shadow_mem[idx_reg[smac_pkg::SH_ADDR_W-1:0]];
    end

    // item payload, offset, clip, bound and limit results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            addr_reg   <= address;
            len_reg    <= length;
        end
        if (cmd.offset)
            off_reg <= off_next;
        if (cmd.clip)
        begin
            e_raw_reg <= t_sum[smac_pkg::LEN_W:0];
            s_reg     <= ge ? off_reg[smac_pkg::LEN_W-1:0] : '0;
        end
        if (cmd.bound)
        begin
            stop_raw_reg <= e_round[33:3];
            tail_reg     <= e_sel[2:0];
        end
        if (cmd.limit)
        begin
            stop_reg <= (stop_raw_reg > smac_pkg::IDX_W'(n_reg))
                      ? n_reg : stop_raw_reg[smac_pkg::SH_CNT_W-1:0];
            last_reg <= stop_raw_reg - 31'd1;
        end
        if (issue)
            pend_last_reg <= at_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
            region_size_reg <= '0;
            n_reg           <= '0;
            idx_reg         <= '0;
            reject_reg      <= 1'b0;
            first_flag_reg  <= 1'b0;
            pend_reg        <= 1'b0;
            fault_reg       <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (cfg_fill)
            begin
                unique case (cfg_index)
                    smac_pkg::REG_BASE: region_base_reg <= cfg_data;
                    smac_pkg::REG_SIZE:
                    begin
                        region_size_reg <= cfg_data[smac_pkg::LEN_W-1:0];
                        n_reg           <= n_next;
                    end
                    default: ;
                endcase
                idx_reg <= '0;
            end
            else
            begin
                if (cmd.load)
                    fault_reg <= 1'b0;
                if (cmd.clip)
                    reject_reg <= reject_next;
                if (cmd.bound)
                begin
                    idx_reg        <= smac_pkg::IDX_W'(s_reg[smac_pkg::LEN_W-1:3]);
                    first_flag_reg <= 1'b1;
                end
                if (mark_we || clear_we || issue)
                    idx_reg <= idx_reg + 31'd1;
                if (mark_we)
                    first_flag_reg <= 1'b0;
                if (hit)
                    fault_reg <= 1'b1;
            end
        end
    end

    assign stat.reject     = reject_reg;
    assign stat.walk_done  = is_check ? (!pend_reg && (!in_range || fault_reg)) : !in_range;
    assign stat.clear_done = !in_fill;
    assign fault           = fault_reg;

endmodule

/* src/smac_ctrl.sv */
// controller: sequences clipping, block walk, result strobe and shadow refill
`include "shadow_memory_access_checker_core_assert.svh"

module smac_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               cfg_fill,
    input  smac_pkg::dp_stat_t stat,
    output smac_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_OFFSET,
        S_CLIP,
        S_BOUND,
        S_LIMIT,
        S_WALK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fill)
                    state_next = S_CLEAR;
                else if (start)
                    state_next = S_OFFSET;
            end
            S_CLEAR:
            begin
                if (!cfg_fill && stat.clear_done)
                    state_next = S_IDLE;
            end
            S_OFFSET: state_next = S_CLIP;
            S_CLIP:   state_next = S_BOUND;
            S_BOUND:  state_next = stat.reject ? S_DONE : S_LIMIT;
            S_LIMIT:  state_next = S_WALK;
            S_WALK:
            begin
                if (stat.walk_done)
                    state_next = S_DONE;
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.load   = (state_reg == S_IDLE) && start && !cfg_fill;
        cmd.offset = (state_reg == S_OFFSET);
        cmd.clip   = (state_reg == S_CLIP);
        cmd.bound  = (state_reg == S_BOUND);
        cmd.limit  = (state_reg == S_LIMIT);
        cmd.walk   = (state_reg == S_WALK);
        cmd.clear  = (state_reg == S_CLEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_next == S_DONE);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `SMAC_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `SMAC_ASSERT_IMPL(a_load_idle, clk, rst_n, cmd.load, !busy_reg)
    `SMAC_ASSERT_IMPL(a_done_state, clk, rst_n, done_reg, busy_reg && (state_reg == S_DONE))
    `SMAC_ASSERT_NEXT(a_walk_hold, clk, rst_n, (state_reg == S_WALK) && !stat.walk_done, state_reg == S_WALK)

endmodule

/* src/shadow_memory_access_checker_core.sv */
// top level of the shadow memory access checker
//
// command channel: a request (action, address, length) is taken at a rising edge
// with start high, busy low and no register write in that cycle; busy stays high
// until the result has been shown
// result: done is high for exactly one cycle with fault valid; the receiver cannot
// stall it, so the result beat is taken at the edge ending that cycle
// every request gives one result beat; poison and unpoison always answer fault 0
// a request rejected outright (zero base or length, outside the region, unused
// action) skips the walk; otherwise poison and unpoison mark their blocks, and a
// check reads its blocks among the entries in use, stopping early on a fault
// the walk runs one shadow entry per cycle through the single memory port,
// and the next start can be taken in the cycle after the result beat
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, cfg_ready
// always high; index 0 is the region base, index 1 the region size
// a write to either register outside a request refills the entries in use,
// ceil(size/8) capped at the shadow depth, with eight, one entry per cycle,
// while busy is held high; reset: region base and size clear to zero, no
// entry is in use, so no refill pass is needed until the first register write
module shadow_memory_access_checker_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [smac_pkg::ACT_W-1:0]      action,
    input  logic [smac_pkg::ADDR_W-1:0]     address,
    input  logic [smac_pkg::LEN_W-1:0]      length,
    output logic                            done,
    output logic                            fault,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [smac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smac_pkg::CFG_DAT_W-1:0]  cfg_data
);

    smac_pkg::dp_cmd_t  cmd;
    smac_pkg::dp_stat_t stat;
    logic               cfg_fill;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // only writes to a known register touch state and trigger the refill
    assign cfg_fill = cfg_valid && cfg_ready
                   && ((cfg_index == smac_pkg::REG_BASE) || (cfg_index == smac_pkg::REG_SIZE));

    smac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cfg_fill (cfg_fill),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    smac_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fill  (cfg_fill),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .action    (action),
        .address   (address),
        .length    (length),
        .cmd       (cmd),
        .stat      (stat),
        .fault     (fault)
    );

endmodule
